@@ sv/ice_pkg.sv @@
// ----------------------------------------------------------------------------
// ISO 7816-3 character engine package
// Shared widths, codes, configuration and result types, and bit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ice_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int WAIT_W      = 24;

  // Item kinds
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_EDGE = 2'd1;
  localparam logic [1:0] ACT_SEND = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_PARITY  = 3'd1;
  localparam logic [2:0] ERR_NACKEX  = 3'd2;
  localparam logic [2:0] ERR_NOSTOP  = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT = 3'd4;
  localparam logic [2:0] ERR_STEP    = 3'd5;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_T1  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_CONV = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WORK_WAIT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAR_WAIT    = 3'd4;

  // Reset values
  localparam logic [3:0]        RETRY_LIMIT_RST = 4'd5;
  localparam logic [WAIT_W-1:0] WORK_WAIT_RST   = 24'd9600;
  localparam logic [WAIT_W-1:0] CHAR_WAIT_RST   = 24'd8203;
  localparam logic [WAIT_W-1:0] GUARD_ETU       = 24'd3;

  typedef struct packed {
    logic              protocol_t1;
    logic              inverse_convention;
    logic [3:0]        retry_limit;
    logic [WAIT_W-1:0] work_wait_etu;
    logic [WAIT_W-1:0] char_wait_etu;
  } cfg_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic       tx_done;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       line_drive;
  } result_t;

  // Bit-reverse and invert a byte (inverse convention).
  function automatic logic [7:0] rev_invert(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = ~b[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/ice_cfg.sv @@
// ----------------------------------------------------------------------------
// ISO 7816-3 character engine configuration registers
// Write-only register file decoded from the index on each write strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ice_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ice_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ice_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ice_pkg::cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_t1        <= 1'b0;
      cfg.inverse_convention <= 1'b0;
      cfg.retry_limit        <= ice_pkg::RETRY_LIMIT_RST;
      cfg.work_wait_etu      <= ice_pkg::WORK_WAIT_RST;
      cfg.char_wait_etu      <= ice_pkg::CHAR_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ice_pkg::REG_PROTOCOL_T1:  cfg.protocol_t1        <= cfg_data[0];
        ice_pkg::REG_INVERSE_CONV: cfg.inverse_convention <= cfg_data[0];
        ice_pkg::REG_RETRY_LIMIT:  cfg.retry_limit        <= cfg_data[3:0];
        ice_pkg::REG_WORK_WAIT:    cfg.work_wait_etu      <= cfg_data[ice_pkg::WAIT_W-1:0];
        ice_pkg::REG_CHAR_WAIT:    cfg.char_wait_etu      <= cfg_data[ice_pkg::WAIT_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/ice_engine.sv @@
// ----------------------------------------------------------------------------
// ISO 7816-3 character engine state machine
// Holds the line/character state and computes one result per advanced item.
// ----------------------------------------------------------------------------
`default_nettype none

module ice_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic [1:0]    action,
  input  wire logic          line_level,
  input  wire logic [7:0]    send_byte,
  input  wire ice_pkg::cfg_t cfg,
  output ice_pkg::result_t   res
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WAIT  = 3'd1,
    M_RX    = 3'd2,
    M_NACK  = 3'd3,
    M_TX    = 3'd4,
    M_GUARD = 3'd5
  } mode_t;

  mode_t                      engine_mode, engine_mode_next;
  logic [3:0]                 bit_position, bit_position_next;
  logic [7:0]                 shift_byte, shift_byte_next;
  logic                       parity_bit, parity_bit_next;
  logic [3:0]                 retries_left, retries_left_next;
  logic [ice_pkg::WAIT_W-1:0] wait_counter, wait_counter_next;
  logic                       line_state, line_state_next;

  logic       armed;
  logic [7:0] rx_conv;
  logic       rx_par;
  logic       rx_ch;
  logic [7:0] tx_conv;
  logic       tx_par;
  logic [3:0] tx_idx;

  assign armed   = (engine_mode == M_IDLE) || (engine_mode == M_WAIT);
  assign rx_conv = cfg.inverse_convention ? ice_pkg::rev_invert(shift_byte) : shift_byte;
  assign rx_par  = ^rx_conv;
  assign rx_ch   = line_level ^ cfg.inverse_convention;
  assign tx_conv = cfg.inverse_convention ? ice_pkg::rev_invert(send_byte) : send_byte;
  assign tx_par  = (^send_byte) ^ cfg.inverse_convention;
  assign tx_idx  = bit_position - 4'd1;

  always_comb begin
    engine_mode_next  = engine_mode;
    bit_position_next = bit_position;
    shift_byte_next   = shift_byte;
    parity_bit_next   = parity_bit;
    retries_left_next = retries_left;
    wait_counter_next = wait_counter;
    line_state_next   = line_state;
    res               = '0;

    case (action)
      ice_pkg::ACT_TICK: begin
        case (engine_mode)
          M_WAIT: begin
            if (wait_counter == '0) begin
              res.error_code   = ice_pkg::ERR_TIMEOUT;
              engine_mode_next = M_IDLE;
              line_state_next  = 1'b1;
            end else begin
              wait_counter_next = wait_counter - 24'd1;
            end
          end
          M_RX: begin
            if (bit_position < 4'd8) begin
              shift_byte_next   = shift_byte | (8'(line_level) << bit_position[2:0]);
              bit_position_next = bit_position + 4'd1;
            end else if (bit_position == 4'd8) begin
              shift_byte_next = rx_conv;
              parity_bit_next = rx_par;
              if (rx_ch != rx_par) begin
                if (cfg.protocol_t1) begin
                  res.error_code   = ice_pkg::ERR_PARITY;
                  engine_mode_next = M_IDLE;
                  line_state_next  = 1'b1;
                end else if (retries_left <= 4'd1) begin
                  retries_left_next = 4'd0;
                  res.error_code    = ice_pkg::ERR_NACKEX;
                  engine_mode_next  = M_IDLE;
                  line_state_next   = 1'b1;
                end else begin
                  retries_left_next = retries_left - 4'd1;
                  bit_position_next = 4'd9;
                end
              end else begin
                if (!cfg.protocol_t1) begin
                  retries_left_next = cfg.retry_limit;
                end
                bit_position_next = 4'd9;
              end
            end else begin
              // stop bit slot
              if (!line_level) begin
                res.error_code   = ice_pkg::ERR_NOSTOP;
                engine_mode_next = M_IDLE;
                line_state_next  = 1'b1;
              end else if (!cfg.protocol_t1 && (retries_left < cfg.retry_limit)) begin
                line_state_next  = 1'b0;
                engine_mode_next = M_NACK;
              end else begin
                res.rx_valid      = 1'b1;
                res.rx_byte       = shift_byte;
                wait_counter_next = cfg.protocol_t1 ? cfg.char_wait_etu : cfg.work_wait_etu;
                engine_mode_next  = M_WAIT;
              end
            end
          end
          M_NACK: begin
            line_state_next  = 1'b1;
            engine_mode_next = M_IDLE;
          end
          M_TX: begin
            if (bit_position == 4'd0) begin
              line_state_next   = 1'b0;
              bit_position_next = 4'd1;
            end else if (bit_position <= 4'd8) begin
              line_state_next   = shift_byte[tx_idx[2:0]];
              bit_position_next = bit_position + 4'd1;
            end else if (bit_position == 4'd9) begin
              line_state_next   = parity_bit;
              bit_position_next = 4'd10;
            end else if (bit_position == 4'd10) begin
              line_state_next = 1'b1;
              if (cfg.protocol_t1) begin
                res.tx_done      = 1'b1;
                engine_mode_next = M_IDLE;
              end else begin
                bit_position_next = 4'd11;
              end
            end else begin
              // NACK slot: low means the card rejected the byte
              if (!line_level) begin
                if (retries_left <= 4'd1) begin
                  retries_left_next = 4'd0;
                  res.error_code    = ice_pkg::ERR_NACKEX;
                  engine_mode_next  = M_IDLE;
                  line_state_next   = 1'b1;
                end else begin
                  retries_left_next = retries_left - 4'd1;
                  wait_counter_next = ice_pkg::GUARD_ETU;
                  engine_mode_next  = M_GUARD;
                end
              end else begin
                res.tx_done      = 1'b1;
                engine_mode_next = M_IDLE;
              end
            end
          end
          M_GUARD: begin
            if (wait_counter == '0) begin
              bit_position_next = 4'd0;
              engine_mode_next  = M_TX;
            end else begin
              wait_counter_next = wait_counter - 24'd1;
            end
          end
          default: ;
        endcase
      end
      ice_pkg::ACT_EDGE: begin
        if (armed) begin
          bit_position_next = 4'd0;
          shift_byte_next   = 8'd0;
          engine_mode_next  = M_RX;
        end else begin
          res.error_code   = ice_pkg::ERR_STEP;
          engine_mode_next = M_IDLE;
          line_state_next  = 1'b1;
        end
      end
      ice_pkg::ACT_SEND: begin
        if (armed) begin
          shift_byte_next = tx_conv;
          parity_bit_next = tx_par;
          if (!cfg.protocol_t1) begin
            retries_left_next = cfg.retry_limit;
          end
          bit_position_next = 4'd0;
          engine_mode_next  = M_TX;
        end else begin
          res.error_code   = ice_pkg::ERR_STEP;
          engine_mode_next = M_IDLE;
          line_state_next  = 1'b1;
        end
      end
      default: ; // undefined kind: no state change
    endcase

    res.line_drive = line_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_mode  <= M_IDLE;
      bit_position <= 4'd0;
      shift_byte   <= 8'd0;
      parity_bit   <= 1'b0;
      retries_left <= ice_pkg::RETRY_LIMIT_RST;
      wait_counter <= '0;
      line_state   <= 1'b1;
    end else if (advance) begin
      engine_mode  <= engine_mode_next;
      bit_position <= bit_position_next;
      shift_byte   <= shift_byte_next;
      parity_bit   <= parity_bit_next;
      retries_left <= retries_left_next;
      wait_counter <= wait_counter_next;
      line_state   <= line_state_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/iso7816_character_engine_unit.sv @@
// ----------------------------------------------------------------------------
// ISO 7816-3 character engine
// Smart-card I/O line character layer: receive, transmit, T=0 retries, waits.
// ----------------------------------------------------------------------------
// Flow: an item goes into the input register, and its result then goes into the result
//   register onto m_tdata. Throughput: one item per cycle unless m_tready stalls the output;
//   the state update is a single pass of logic.
// Reset: synchronous rst empties both registers, releases the line, sets the
//   engine idle and loads configuration reset values.
`default_nettype none

module iso7816_character_engine_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [ice_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ice_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  input  wire logic [15:0]                     s_tdata,  // [0] line_level, [8:1] send_byte
  input  wire logic [1:0]                      s_tuser,  // [1:0] action
  // result items
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // [0] line_drive, [1] rx_valid, [9:2] rx_byte, [10] tx_done, [13:11] error_code
  output      logic [15:0]                     m_tdata
);

  ice_pkg::cfg_t    cfg;
  ice_pkg::result_t res;

  logic       in_valid;
  logic [1:0] in_action;
  logic       in_level;
  logic [7:0] in_byte;
  logic       advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  ice_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ice_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .action     (in_action),
    .line_level (in_level),
    .send_byte  (in_byte),
    .cfg        (cfg),
    .res        (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_level  <= s_tdata[0];
      in_byte   <= s_tdata[8:1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {2'b00, res};
    end
  end

endmodule

`default_nettype wire
